### rtl/core/cpuex_pkg.sv
// ----------------------------------------------------------------------------
// cpuex_pkg
// Shared types and constants for the opcode 0x19..0x3F execute block.
// ----------------------------------------------------------------------------
package cpuex_pkg;

	localparam int unsigned QueueDepth = 2;
	localparam int unsigned OutDepth   = 2;

	typedef enum logic [2:0] {
		GRP_NONE, GRP_ALU, GRP_LOAD, GRP_MEM, GRP_JUMP
	} grp_t;

	typedef struct packed {
		grp_t        grp;
		logic [5:0]  operation;
		logic [7:0]  imm_low;
		logic [7:0]  imm_high;
		logic [7:0]  mem_rdata;
		logic [15:0] instr_pc;
		logic [15:0] jump_pc;
	} dec_item_t;

	typedef struct packed {
		logic [7:0]  acc_value;
		logic [3:0]  flag_bits;
		logic [15:0] hl_value;
		logic [15:0] de_value;
		logic [15:0] sp_value;
		logic [15:0] mem_addr;
		logic        mem_read;
		logic        mem_write;
		logic [7:0]  mem_wdata;
		logic        branch_taken;
		logic [15:0] next_pc;
	} result_t;

endpackage

### rtl/core/cpuex_front.sv
// ----------------------------------------------------------------------------
// cpuex_front
// Accept instructions, classify opcode, precompute jump target, queue them.
// ----------------------------------------------------------------------------
module cpuex_front #(
	parameter int unsigned DEPTH = cpuex_pkg::QueueDepth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [5:0]            operation,
	input  logic [7:0]            imm_low,
	input  logic [7:0]            imm_high,
	input  logic [7:0]            mem_rdata,
	input  logic [15:0]           instr_pc,
	output logic                  q_valid,
	input  logic                  q_take,
	output cpuex_pkg::dec_item_t  q_item
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cpuex_pkg::dec_item_t mem_q [DEPTH];
	cpuex_pkg::dec_item_t din;
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          do_push, do_pop;

	always_comb begin
		din           = '0;
		din.operation = operation;
		din.imm_low   = imm_low;
		din.imm_high  = imm_high;
		din.mem_rdata = mem_rdata;
		din.instr_pc  = instr_pc;
		din.jump_pc   = instr_pc + {{8{imm_low[7]}}, imm_low};
		unique case (operation)
			6'h20, 6'h28, 6'h30, 6'h38: din.grp = cpuex_pkg::GRP_JUMP;
			6'h1A, 6'h2A, 6'h3A: din.grp = cpuex_pkg::GRP_LOAD;
			6'h22, 6'h32, 6'h34, 6'h35, 6'h36: din.grp = cpuex_pkg::GRP_MEM;
			default: din.grp = (operation >= 6'h19) ? cpuex_pkg::GRP_ALU
				: cpuex_pkg::GRP_NONE;
		endcase
	end

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign q_valid = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop  = q_take && q_valid;
	assign q_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue count overflow");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		full && !q_take |=> full) else $error("queue full dropped");
	a_push_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("push lost");
endmodule

### rtl/core/cpuex_back.sv
// ----------------------------------------------------------------------------
// cpuex_back
// Execute queued instructions on the register file, buffer results.
// ----------------------------------------------------------------------------
module cpuex_back #(
	parameter int unsigned DEPTH = cpuex_pkg::OutDepth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_take,
	input  cpuex_pkg::dec_item_t  q_item,
	output logic                  o_valid,
	input  logic                  o_take,
	output cpuex_pkg::result_t    o_res
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0]  acc_q, d_q, e_q, h_q, l_q;
	logic [3:0]  f_q;
	logic [15:0] sp_q;
	logic [7:0]  na, nd, ne, nh, nl, inc_v, dec_v, src, daa_v, corr;
	logic [3:0]  nf, inc_f, dec_f, daa_f, add_f;
	logic [15:0] nsp, hl, de, addb, add_r;
	logic [12:0] hsum;
	logic [16:0] fsum;
	cpuex_pkg::result_t r;
	cpuex_pkg::result_t res_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          ofull, sub;
	logic [5:0]    op;

	assign hl     = {h_q, l_q};
	assign de     = {d_q, e_q};
	assign ofull  = (cnt_q == (AW+1)'(DEPTH));
	assign q_take = q_valid && !ofull;
	assign op     = q_item.operation;

	always_comb begin
		unique case (op)
			6'h1C, 6'h1D: src = e_q;
			6'h24, 6'h25: src = h_q;
			6'h2C, 6'h2D: src = l_q;
			6'h34, 6'h35: src = q_item.mem_rdata;
			default: src = acc_q;
		endcase
		inc_v = src + 8'd1;
		dec_v = src - 8'd1;
		inc_f = {inc_v == 8'd0, 1'b0, src[3:0] == 4'hF, f_q[0]};
		dec_f = {dec_v == 8'd0, 1'b1, src[3:0] == 4'h0, f_q[0]};
		unique case (op)
			6'h19: addb = de;
			6'h29: addb = hl;
			default: addb = sp_q;
		endcase
		hsum  = {1'b0, hl[11:0]} + {1'b0, addb[11:0]};
		fsum  = {1'b0, hl} + {1'b0, addb};
		add_r = fsum[15:0];
		add_f = {f_q[3], 1'b0, hsum[12], fsum[16]};
		sub   = f_q[2];
		corr  = '0;
		daa_f = f_q;
		if (f_q[1] || (!sub && acc_q[3:0] > 4'd9)) begin
			corr[2:1] = 2'b11;
		end
		if (f_q[0] || (!sub && acc_q > 8'h99)) begin
			corr[6:5] = 2'b11;
			daa_f[0]  = 1'b1;
		end
		daa_v = sub ? acc_q - corr : acc_q + corr;
		daa_f = {daa_v == 8'd0, daa_f[2], 1'b0, daa_f[0]};

		na = acc_q; nf = f_q; nd = d_q; ne = e_q; nh = h_q; nl = l_q; nsp = sp_q;
		r  = '0;
		r.next_pc = q_item.instr_pc;
		unique case (op)
			6'h19, 6'h29, 6'h39: {nh, nl, nf} = {add_r, add_f};
			6'h1A: begin
				r.mem_addr = de; r.mem_read = 1'b1; na = q_item.mem_rdata;
			end
			6'h1B: {nd, ne} = de - 16'd1;
			6'h1C: {ne, nf} = {inc_v, inc_f};
			6'h1D: {ne, nf} = {dec_v, dec_f};
			6'h1E: ne = q_item.imm_low;
			6'h1F: begin
				na = {f_q[0], acc_q[7:1]}; nf = {3'b000, acc_q[0]};
			end
			6'h20: r.branch_taken = !f_q[3];
			6'h21: {nh, nl} = {q_item.imm_high, q_item.imm_low};
			6'h22: begin
				r.mem_addr = hl; r.mem_write = 1'b1; r.mem_wdata = acc_q;
				{nh, nl} = hl + 16'd1;
			end
			6'h23: {nh, nl} = hl + 16'd1;
			6'h24: {nh, nf} = {inc_v, inc_f};
			6'h25: {nh, nf} = {dec_v, dec_f};
			6'h26: nh = q_item.imm_low;
			6'h27: {na, nf} = {daa_v, daa_f};
			6'h28: r.branch_taken = f_q[3];
			6'h2A: begin
				r.mem_addr = hl; r.mem_read = 1'b1; na = q_item.mem_rdata;
				{nh, nl} = hl + 16'd1;
			end
			6'h2B: {nh, nl} = hl - 16'd1;
			6'h2C: {nl, nf} = {inc_v, inc_f};
			6'h2D: {nl, nf} = {dec_v, dec_f};
			6'h2E: nl = q_item.imm_low;
			6'h2F: begin
				na = ~acc_q; nf = f_q | 4'b0110;
			end
			6'h30: r.branch_taken = !f_q[0];
			6'h31: nsp = {q_item.imm_high, q_item.imm_low};
			6'h32: begin
				r.mem_addr = hl; r.mem_write = 1'b1; r.mem_wdata = acc_q;
				{nh, nl} = hl - 16'd1;
			end
			6'h33: nsp = sp_q + 16'd1;
			6'h34: begin
				r.mem_addr = hl; r.mem_read = 1'b1; r.mem_write = 1'b1;
				r.mem_wdata = inc_v; nf = inc_f;
			end
			6'h35: begin
				r.mem_addr = hl; r.mem_read = 1'b1; r.mem_write = 1'b1;
				r.mem_wdata = dec_v; nf = dec_f;
			end
			6'h36: begin
				r.mem_addr = hl; r.mem_write = 1'b1; r.mem_wdata = q_item.imm_low;
			end
			6'h37: nf = {f_q[3], 3'b001};
			6'h38: r.branch_taken = f_q[0];
			6'h3A: begin
				r.mem_addr = hl; r.mem_read = 1'b1; na = q_item.mem_rdata;
				{nh, nl} = hl - 16'd1;
			end
			6'h3B: nsp = sp_q - 16'd1;
			6'h3C: {na, nf} = {inc_v, inc_f};
			6'h3D: {na, nf} = {dec_v, dec_f};
			6'h3E: na = q_item.imm_low;
			6'h3F: nf = {f_q[3], 2'b00, !f_q[0]};
			default: ;
		endcase
		if (r.branch_taken) begin
			r.next_pc = q_item.jump_pc;
		end
		r.acc_value = na;
		r.flag_bits = nf;
		r.hl_value  = {nh, nl};
		r.de_value  = {nd, ne};
		r.sp_value  = nsp;
	end

	assign o_valid = (cnt_q != '0);
	assign o_res   = res_q[rd_q];

	always_ff @(posedge clk) begin
		if (q_take) begin
			res_q[wr_q] <= r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0; f_q <= '0; d_q <= '0; e_q <= '0;
			h_q <= '0; l_q <= '0; sp_q <= '0;
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (q_take) begin
				acc_q <= na; f_q <= nf; d_q <= nd; e_q <= ne;
				h_q <= nh; l_q <= nl; sp_q <= nsp;
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (o_take && o_valid) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(q_take) - (AW+1)'(o_take && o_valid);
		end
	end

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		ofull && !o_take |=> $stable(acc_q) && $stable(hl))
		else $error("state moved while stalled");
	a_rw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		r.branch_taken |-> !r.mem_read && !r.mem_write)
		else $error("jump with memory access");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("result buffer overflow");
endmodule

### rtl/core/cpu_opcode_block_19_to_3f_execute.sv
// ----------------------------------------------------------------------------
// cpu_opcode_block_19_to_3f_execute
// Execute stage for opcodes 0x19..0x3F: front decode queue, back execute unit.
// ----------------------------------------------------------------------------
// Path: a push writes the decode queue; the execute unit then writes the result buffer, stalling while it is full.
// Throughput: one transaction per cycle while the result buffer is not full.
// By default both queues hold two entries, so the block absorbs short pop stalls.
// Reset clears A, flags, D, E, H, L, SP and empties both queues.
module cpu_opcode_block_19_to_3f_execute #(
	parameter int unsigned QUEUE_DEPTH = cpuex_pkg::QueueDepth,
	parameter int unsigned OUT_DEPTH   = cpuex_pkg::OutDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [5:0]  operation,
	input  logic [7:0]  imm_low,
	input  logic [7:0]  imm_high,
	input  logic [7:0]  mem_rdata,
	input  logic [15:0] instr_pc,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  acc_value,
	output logic [3:0]  flag_bits,
	output logic [15:0] hl_value,
	output logic [15:0] de_value,
	output logic [15:0] sp_value,
	output logic [15:0] mem_addr,
	output logic        mem_read,
	output logic        mem_write,
	output logic [7:0]  mem_wdata,
	output logic        branch_taken,
	output logic [15:0] next_pc
);
	logic                 q_valid, q_take, o_valid;
	cpuex_pkg::dec_item_t q_item;
	cpuex_pkg::result_t   o_res;

	cpuex_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk, .arst_n, .push, .full, .operation, .imm_low, .imm_high,
		.mem_rdata, .instr_pc, .q_valid, .q_take, .q_item
	);

	cpuex_back #(.DEPTH(OUT_DEPTH)) u_back (
		.clk, .arst_n, .q_valid, .q_take, .q_item,
		.o_valid, .o_take(pop), .o_res
	);

	assign empty        = !o_valid;
	assign acc_value    = o_res.acc_value;
	assign flag_bits    = o_res.flag_bits;
	assign hl_value     = o_res.hl_value;
	assign de_value     = o_res.de_value;
	assign sp_value     = o_res.sp_value;
	assign mem_addr     = o_res.mem_addr;
	assign mem_read     = o_res.mem_read;
	assign mem_write    = o_res.mem_write;
	assign mem_wdata    = o_res.mem_wdata;
	assign branch_taken = o_res.branch_taken;
	assign next_pc      = o_res.next_pc;
endmodule
